// ===== hdl/dha_pkg.sv =====
// ----------------------------------------------------------------------------
// dha_pkg
// Codes shared by the dense handle allocator: actions, status, sequencer states.
// ----------------------------------------------------------------------------
package dha_pkg;

    localparam logic [1:0] ACT_ALLOC      = 2'd0;
    localparam logic [1:0] ACT_INVALIDATE = 2'd1;
    localparam logic [1:0] ACT_FREE       = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_STALE = 2'd2;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ1 = 3'd1;
    localparam logic [2:0] ST_READ2 = 3'd2;
    localparam logic [2:0] ST_FIX   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

endpackage

// ===== hdl/dense_handle_allocator.sv =====
// Sequence from accept to result valid: an immediate error goes straight to DONE;
// allocate passes READ1; a stale handle READ1 and maybe READ2; invalidate READ1 and
// READ2; free READ1, READ2 and FIX (FIX only when another entry moves). Transactions
// run one at a time (s_tready only in IDLE), read-modify-write on slot and dense memory.
// Reset: control state clears at once, no clearing pass; generation entries at or
// above the fill count read as one.
// ----------------------------------------------------------------------------
// dense_handle_allocator
// Slot map with generation counters, LIFO free list and a packed dense array.
// ----------------------------------------------------------------------------
module dense_handle_allocator
    import dha_pkg::*;
#(
    parameter int SLOT_COUNT      = 1024,
    parameter int GENERATION_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [$clog2(SLOT_COUNT+1)-1:0]         cfg_wr_data,   // capacity_limit
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // action, handle_generation, handle_index
    input  logic [((2+GENERATION_BITS+$clog2(SLOT_COUNT)+7)/8)*8-1:0] s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // status, out_generation, out_index, copy_from_index, copy_to_index, live_count
    output logic [((2+GENERATION_BITS+3*$clog2(SLOT_COUNT)+$clog2(SLOT_COUNT+1)+7)/8)*8-1:0]
                                                    m_tdata
);

    localparam int IDX_W   = $clog2(SLOT_COUNT);
    localparam int COUNT_W = $clog2(SLOT_COUNT + 1);
    localparam int GEN_W   = GENERATION_BITS;
    localparam int IN_W    = 2 + GEN_W + IDX_W;
    localparam int OUT_W   = 2 + GEN_W + 3 * IDX_W + COUNT_W;
    localparam int OUT_PADW = ((OUT_W + 7) / 8) * 8;
    // slot entry: {generation, end_of_list, link, sparse_to_dense}
    localparam int SLOT_W  = GEN_W + 1 + 2 * IDX_W;
    localparam logic [COUNT_W-1:0] SLOT_COUNT_C = COUNT_W'(SLOT_COUNT);
    localparam logic [GEN_W-1:0]   GEN_ONE      = GEN_W'(1);

    // memories
    logic [SLOT_W-1:0] slot_mem  [SLOT_COUNT];
    logic [IDX_W-1:0]  dense_mem [SLOT_COUNT];

    logic              slot_rd_en;
    logic [IDX_W-1:0]  slot_rd_addr;
    logic [SLOT_W-1:0] slot_rdata_reg;
    logic              slot_wr_en;
    logic [IDX_W-1:0]  slot_wr_addr;
    logic [SLOT_W-1:0] slot_wr_data;

    logic              dense_rd_en;
    logic [IDX_W-1:0]  dense_rd_addr_a;
    logic [IDX_W-1:0]  dense_rd_addr_b;
    logic [IDX_W-1:0]  dense_rdata_a_reg;
    logic [IDX_W-1:0]  dense_rdata_b_reg;
    logic              dense_wr_en;
    logic [IDX_W-1:0]  dense_wr_addr;
    logic [IDX_W-1:0]  dense_wr_data;

    // control state
    logic [2:0]         state_reg, state_next;
    logic [COUNT_W-1:0] cap_reg;
    logic [COUNT_W-1:0] live_reg, live_next;
    logic [COUNT_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic               empty_reg, empty_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // payload
    logic [1:0]          act_reg, act_next;
    logic [GEN_W-1:0]    hgen_reg, hgen_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic                fresh_reg, fresh_next;
    logic [IDX_W-1:0]    moved_reg, moved_next;
    logic [IDX_W-1:0]    hole_reg, hole_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic [GEN_W-1:0]    res_gen_reg, res_gen_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;
    logic [IDX_W-1:0]    res_from_reg, res_from_next;
    logic [IDX_W-1:0]    res_to_reg, res_to_next;
    logic [OUT_PADW-1:0] m_tdata_reg, m_tdata_next;

    // input fields
    logic [1:0]       in_action;
    logic [GEN_W-1:0] in_gen;
    logic [IDX_W-1:0] in_idx;

    // fields of the slot entry last read
    logic [IDX_W-1:0] rd_s2d;
    logic [IDX_W-1:0] rd_link;
    logic             rd_end;
    logic [GEN_W-1:0] rd_gen;
    logic [GEN_W-1:0] gen_eff;
    logic [GEN_W-1:0] gen_bumped;
    logic [COUNT_W-1:0] eff_cap;
    logic [IDX_W-1:0] last_pos;
    logic [IDX_W-1:0] alloc_addr;

    assign in_action = s_tdata[1:0];
    assign in_gen    = s_tdata[2+GEN_W-1:2];
    assign in_idx    = s_tdata[IN_W-1:2+GEN_W];

    assign rd_s2d  = slot_rdata_reg[IDX_W-1:0];
    assign rd_link = slot_rdata_reg[2*IDX_W-1:IDX_W];
    assign rd_end  = slot_rdata_reg[2*IDX_W];
    assign rd_gen  = slot_rdata_reg[SLOT_W-1:2*IDX_W+1];

    // slots never handed out keep the reset generation
    assign gen_eff    = fresh_reg ? GEN_ONE : rd_gen;
    assign gen_bumped = gen_eff + GEN_ONE;
    assign eff_cap    = (cap_reg > SLOT_COUNT_C) ? SLOT_COUNT_C : cap_reg;
    assign last_pos   = IDX_W'(live_reg - COUNT_W'(1));
    assign alloc_addr = empty_reg ? live_reg[IDX_W-1:0] : head_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        state_next      = state_reg;
        live_next       = live_reg;
        fill_next       = fill_reg;
        head_next       = head_reg;
        empty_next      = empty_reg;
        act_next        = act_reg;
        hgen_next       = hgen_reg;
        slot_next       = slot_reg;
        fresh_next      = fresh_reg;
        moved_next      = moved_reg;
        hole_next       = hole_reg;
        res_status_next = res_status_reg;
        res_gen_next    = res_gen_reg;
        res_idx_next    = res_idx_reg;
        res_from_next   = res_from_reg;
        res_to_next     = res_to_reg;
        m_tdata_next    = m_tdata_reg;
        m_tvalid_next   = m_tvalid_reg & ~m_tready;

        slot_rd_en      = 1'b0;
        slot_rd_addr    = '0;
        slot_wr_en      = 1'b0;
        slot_wr_addr    = '0;
        slot_wr_data    = '0;
        dense_rd_en     = 1'b0;
        dense_rd_addr_a = '0;
        dense_rd_addr_b = '0;
        dense_wr_en     = 1'b0;
        dense_wr_addr   = '0;
        dense_wr_data   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next        = in_action;
                    hgen_next       = in_gen;
                    res_status_next = STATUS_OK;
                    res_gen_next    = '0;
                    res_idx_next    = '0;
                    res_from_next   = '0;
                    res_to_next     = '0;
                    if (in_action == ACT_ALLOC)
                    begin
                        if (live_reg >= eff_cap)
                        begin
                            res_status_next = STATUS_FULL;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            slot_next    = alloc_addr;
                            fresh_next   = (COUNT_W'(alloc_addr) >= fill_reg);
                            slot_rd_en   = 1'b1;
                            slot_rd_addr = alloc_addr;
                            state_next   = ST_READ1;
                        end
                    end
                    else if ((in_action == ACT_INVALIDATE || in_action == ACT_FREE) &&
                             (COUNT_W'(in_idx) < SLOT_COUNT_C))
                    begin
                        slot_next    = in_idx;
                        fresh_next   = (COUNT_W'(in_idx) >= fill_reg);
                        slot_rd_en   = 1'b1;
                        slot_rd_addr = in_idx;
                        state_next   = ST_READ1;
                    end
                    else
                    begin
                        res_status_next = STATUS_STALE;
                        state_next      = ST_DONE;
                    end
                end
            end

            ST_READ1:
            begin
                if (act_reg == ACT_ALLOC)
                begin
                    slot_wr_en    = 1'b1;
                    slot_wr_addr  = slot_reg;
                    slot_wr_data  = {gen_eff, rd_end, rd_link, live_reg[IDX_W-1:0]};
                    dense_wr_en   = 1'b1;
                    dense_wr_addr = live_reg[IDX_W-1:0];
                    dense_wr_data = slot_reg;
                    live_next     = live_reg + COUNT_W'(1);
                    if (fresh_reg)
                    begin
                        fill_next = fill_reg + COUNT_W'(1);
                    end
                    if (!empty_reg)
                    begin
                        empty_next = rd_end;
                        head_next  = rd_end ? '0 : rd_link;
                    end
                    res_gen_next = gen_eff;
                    res_idx_next = slot_reg;
                    state_next   = ST_DONE;
                end
                else if (gen_eff != hgen_reg)
                begin
                    res_status_next = STATUS_STALE;
                    state_next      = ST_DONE;
                end
                else
                begin
                    // a live slot maps back from its dense position; this holds
                    // even when the slot's own map entry was never written
                    dense_rd_en     = 1'b1;
                    dense_rd_addr_a = rd_s2d;
                    dense_rd_addr_b = last_pos;
                    state_next      = ST_READ2;
                end
            end

            ST_READ2:
            begin
                if (!((COUNT_W'(rd_s2d) < live_reg) && (dense_rdata_a_reg == slot_reg)))
                begin
                    res_status_next = STATUS_STALE;
                    state_next      = ST_DONE;
                end
                else if (act_reg == ACT_INVALIDATE)
                begin
                    slot_wr_en   = 1'b1;
                    slot_wr_addr = slot_reg;
                    slot_wr_data = {gen_bumped, rd_end, rd_link, rd_s2d};
                    res_gen_next = gen_bumped;
                    res_idx_next = slot_reg;
                    state_next   = ST_DONE;
                end
                else
                begin
                    slot_wr_en    = 1'b1;
                    slot_wr_addr  = slot_reg;
                    slot_wr_data  = {gen_bumped, empty_reg, head_reg, rd_s2d};
                    dense_wr_en   = 1'b1;
                    dense_wr_addr = rd_s2d;
                    dense_wr_data = dense_rdata_b_reg;
                    head_next     = slot_reg;
                    empty_next    = 1'b0;
                    live_next     = live_reg - COUNT_W'(1);
                    res_from_next = last_pos;
                    res_to_next   = rd_s2d;
                    moved_next    = dense_rdata_b_reg;
                    hole_next     = rd_s2d;
                    // freeing the last dense entry: nothing else moves
                    if (dense_rdata_b_reg != slot_reg)
                    begin
                        slot_rd_en   = 1'b1;
                        slot_rd_addr = dense_rdata_b_reg;
                        state_next   = ST_FIX;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_FIX:
            begin
                slot_wr_en   = 1'b1;
                slot_wr_addr = moved_reg;
                slot_wr_data = {rd_gen, rd_end, rd_link, hole_reg};
                state_next   = ST_DONE;
            end

            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_PADW'({live_reg, res_to_reg, res_from_reg,
                                               res_idx_reg, res_gen_reg, res_status_reg});
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (slot_wr_en)
        begin
            slot_mem[slot_wr_addr] <= slot_wr_data;
        end
        if (slot_rd_en)
        begin
            slot_rdata_reg <= slot_mem[slot_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dense_wr_en)
        begin
            dense_mem[dense_wr_addr] <= dense_wr_data;
        end
        if (dense_rd_en)
        begin
            dense_rdata_a_reg <= dense_mem[dense_rd_addr_a];
            dense_rdata_b_reg <= dense_mem[dense_rd_addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cap_reg      <= SLOT_COUNT_C;
            live_reg     <= '0;
            fill_reg     <= '0;
            head_reg     <= '0;
            empty_reg    <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            live_reg     <= live_next;
            fill_reg     <= fill_next;
            head_reg     <= head_next;
            empty_reg    <= empty_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        hgen_reg       <= hgen_next;
        slot_reg       <= slot_next;
        fresh_reg      <= fresh_next;
        moved_reg      <= moved_next;
        hole_reg       <= hole_next;
        res_status_reg <= res_status_next;
        res_gen_reg    <= res_gen_next;
        res_idx_reg    <= res_idx_next;
        res_from_reg   <= res_from_next;
        res_to_reg     <= res_to_next;
        m_tdata_reg    <= m_tdata_next;
    end

`ifndef SYNTHESIS
    // every live slot has been handed out at least once
    assert property (@(posedge clk) disable iff (!rst_n) live_reg <= fill_reg)
        else $error("live count above fill count");

    // with no free slot, the handed-out slots are exactly the live ones
    assert property (@(posedge clk) disable iff (!rst_n) empty_reg |-> (live_reg == fill_reg))
        else $error("free list empty but slots missing");

    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= SLOT_COUNT_C)
        else $error("fill count beyond slot count");

    assert property (@(posedge clk) disable iff (!rst_n)
                     (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted transaction not processed");
`endif

endmodule

// ===== verif/dense_handle_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// dense_handle_allocator_checker
// Watches the config port and both stream channels of the handle allocator,
// keeps a cycle-free copy of the slot map (generations, free list, dense maps),
// and compares every result transaction with the predicted one in order.
// ----------------------------------------------------------------------------
module dense_handle_allocator_checker
    import dha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,     // action, handle_generation, handle_index
    input  logic        m_tvalid,
    input  logic        m_tready,
    // status, out_generation, out_index, copy_from_index, copy_to_index, live_count
    input  logic [63:0] m_tdata,
    output int          mismatch_count,
    output int          results_pending
);

    localparam int SLOTS = 1024;

    // first field in the lowest bits, as on m_tdata
    typedef struct packed {
        logic [10:0] live_count;
        logic [9:0]  copy_to_index;
        logic [9:0]  copy_from_index;
        logic [9:0]  out_index;
        logic [15:0] out_generation;
        logic [1:0]  status;
    } slot_result_t;

    logic [15:0] slot_gen      [SLOTS];
    logic [9:0]  next_free     [SLOTS];
    logic        free_tail     [SLOTS];
    logic [9:0]  slot_to_pos   [SLOTS];
    logic [9:0]  pos_to_slot   [SLOTS];
    logic [9:0]  free_head;
    logic        free_none;
    logic [10:0] live_total;
    logic [10:0] capacity;

    slot_result_t predicted_q[$];
    int           results_seen;

    function automatic bit slot_is_live(input logic [9:0] slot, input logic [15:0] gen);
        logic [9:0] pos;
        pos = slot_to_pos[slot];
        return (slot_gen[slot] == gen) && ({1'b0, pos} < live_total) && (pos_to_slot[pos] == slot);
    endfunction

    function automatic slot_result_t apply_handle_op(input logic [1:0] act,
                                                     input logic [15:0] gen,
                                                     input logic [9:0] slot);
        slot_result_t res;
        logic [10:0]  limit;
        logic [9:0]   pick;
        logic [9:0]   last;
        logic [9:0]   hole;
        logic [9:0]   moved;
        res   = '0;
        limit = (capacity > 11'd1024) ? 11'd1024 : capacity;
        case (act)
            ACT_ALLOC:
            begin
                if (live_total >= limit)
                    res.status = STATUS_FULL;
                else
                begin
                    if (!free_none)
                    begin
                        pick      = free_head;
                        free_none = free_tail[pick];
                        free_head = free_none ? 10'd0 : next_free[pick];
                    end
                    else
                        pick = live_total[9:0];
                    slot_to_pos[pick]            = live_total[9:0];
                    pos_to_slot[live_total[9:0]] = pick;
                    live_total                   = live_total + 11'd1;
                    res.out_generation           = slot_gen[pick];
                    res.out_index                = pick;
                end
            end
            ACT_INVALIDATE, ACT_FREE:
            begin
                if (!slot_is_live(slot, gen))
                    res.status = STATUS_STALE;
                else
                begin
                    slot_gen[slot] = slot_gen[slot] + 16'd1;
                    if (act == ACT_INVALIDATE)
                    begin
                        res.out_generation = slot_gen[slot];
                        res.out_index      = slot;
                    end
                    else
                    begin
                        // last dense entry moves into the hole left by the freed slot
                        last               = live_total[9:0] - 10'd1;
                        hole               = slot_to_pos[slot];
                        moved              = pos_to_slot[last];
                        next_free[slot]    = free_head;
                        free_tail[slot]    = free_none;
                        free_head          = slot;
                        free_none          = 1'b0;
                        slot_to_pos[moved] = hole;
                        pos_to_slot[hole]  = moved;
                        live_total         = live_total - 11'd1;
                        res.copy_from_index = last;
                        res.copy_to_index   = hole;
                    end
                end
            end
            default:
                res.status = STATUS_STALE;
        endcase
        res.live_count = live_total;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        slot_result_t want;
        slot_result_t got;
        int           k;
        if (!rst_n)
        begin
            for (k = 0; k < SLOTS; k++)
            begin
                slot_gen[k]    = 16'd1;
                next_free[k]   = '0;
                free_tail[k]   = 1'b0;
                slot_to_pos[k] = '0;
                pos_to_slot[k] = '0;
            end
            free_head = '0;
            free_none = 1'b1;
            live_total = '0;
            capacity = 11'd1024;
            predicted_q.delete();
            results_pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
                capacity = cfg_wr_data;
            if (s_tvalid && s_tready)
                predicted_q.push_back(apply_handle_op(s_tdata[1:0], s_tdata[17:2], s_tdata[27:18]));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[58:0];
                results_seen++;
                if (predicted_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d: unexpected transaction, status %0d gen %h idx %0d",
                                 results_seen, got.status, got.out_generation, got.out_index);
                end
                else
                begin
                    want = predicted_q.pop_front();
                    if (got.status !== want.status || got.out_generation !== want.out_generation
                        || got.out_index !== want.out_index
                        || got.copy_from_index !== want.copy_from_index
                        || got.copy_to_index !== want.copy_to_index
                        || got.live_count !== want.live_count)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("result %0d: expected st %0d gen %h idx %0d from %0d to %0d live %0d",
                                     results_seen, want.status, want.out_generation, want.out_index,
                                     want.copy_from_index, want.copy_to_index, want.live_count);
                            $display("result %0d:      got st %0d gen %h idx %0d from %0d to %0d live %0d",
                                     results_seen, got.status, got.out_generation, got.out_index,
                                     got.copy_from_index, got.copy_to_index, got.live_count);
                        end
                    end
                end
            end
            results_pending = predicted_q.size();
        end
    end

endmodule

// ===== verif/dense_handle_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// dense_handle_allocator_tb
// Stimulus for the handle allocator: a directed pass over full table, stale
// handles, unknown action, swap-on-free and lowered capacity, then random
// allocate/invalidate/free traffic built from handles learned off the result
// stream, under three idle patterns and two capacity settings.
// ----------------------------------------------------------------------------
module dense_handle_allocator_tb;
    import dha_pkg::*;

    localparam logic [1:0] ACT_RESERVED = 2'd3;
    localparam int         QUIET_LIMIT  = 3000;

    typedef struct {
        logic [1:0] act;
        logic [9:0] slot;
    } issued_op_t;

    typedef struct {
        logic [9:0]  slot;
        logic [15:0] gen;
    } slot_handle_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [10:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic [31:0] s_tdata     = '0;     // action, handle_generation, handle_index
    logic        m_tready    = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    // status, out_generation, out_index, copy_from_index, copy_to_index, live_count
    logic [63:0] m_tdata;

    int mismatch_count;
    int results_pending;

    slot_handle_t live_handles[$];
    issued_op_t   issued_ops[$];
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           fill_mark     = 0;
    int           quiet_cycles  = 0;
    int           n_alloc, n_inval, n_free, n_full, n_stale;

    always #10 clk = ~clk;

    dense_handle_allocator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    dense_handle_allocator_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // learn live handles from the result stream so stimulus can reuse them
    always @(posedge clk)
    begin : handle_tracker
        issued_op_t op;
        int         k;
        if (s_tvalid && s_tready)
            issued_ops.push_back('{s_tdata[1:0], s_tdata[27:18]});
        if (m_tvalid && m_tready && issued_ops.size() > 0)
        begin
            op = issued_ops.pop_front();
            case (m_tdata[1:0])
                STATUS_OK:
                begin
                    case (op.act)
                        ACT_ALLOC:
                        begin
                            n_alloc++;
                            live_handles.push_back('{m_tdata[27:18], m_tdata[17:2]});
                            if (m_tdata[27:18] >= fill_mark)
                                fill_mark = m_tdata[27:18] + 1;
                        end
                        ACT_INVALIDATE:
                        begin
                            n_inval++;
                            for (k = 0; k < live_handles.size(); k++)
                                if (live_handles[k].slot == op.slot)
                                    live_handles[k].gen = m_tdata[17:2];
                        end
                        default:
                        begin
                            n_free++;
                            for (k = 0; k < live_handles.size(); k++)
                                if (live_handles[k].slot == op.slot)
                                begin
                                    live_handles.delete(k);
                                    break;
                                end
                        end
                    endcase
                end
                STATUS_FULL: n_full++;
                default:     n_stale++;
            endcase
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial
    begin : watchdog
        do
            @(negedge clk);
        while (quiet_cycles < QUIET_LIMIT);
        $display("no transaction for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, results_pending);
        $display("dense_handle_allocator: mismatch");
        $finish;
    end

    task automatic send_op(input logic [1:0] act, input logic [15:0] gen, input logic [9:0] slot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, slot, gen, act};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_drained;
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (results_pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic set_capacity(input int value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[10:0];
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [15:0] gen_of(input logic [9:0] slot);
        foreach (live_handles[k])
            if (live_handles[k].slot == slot)
                return live_handles[k].gen;
        return 16'd0;
    endfunction

    // mostly well-formed traffic on known handles; the rest wrong generations,
    // arbitrary handles on touched slots, and the unused action code
    task automatic random_op(input int alloc_w, input int free_w, input int inval_w);
        int           r;
        logic [9:0]   any_slot;
        logic [1:0]   act;
        slot_handle_t h;
        r        = $urandom_range(99);
        any_slot = (fill_mark > 0) ? 10'($urandom_range(fill_mark - 1)) : 10'd0;
        act      = $urandom_range(1) ? ACT_FREE : ACT_INVALIDATE;
        if (live_handles.size() == 0 || r < alloc_w)
            send_op(ACT_ALLOC, 16'($urandom), any_slot);
        else
        begin
            h = live_handles[$urandom_range(live_handles.size() - 1)];
            if (r < alloc_w + free_w)
                send_op(ACT_FREE, h.gen, h.slot);
            else if (r < alloc_w + free_w + inval_w)
                send_op(ACT_INVALIDATE, h.gen, h.slot);
            else
                case ($urandom_range(2))
                    0:       send_op(act, h.gen ^ 16'($urandom_range(16'hFFFF, 1)), h.slot);
                    1:       send_op(ACT_RESERVED, 16'($urandom), any_slot);
                    default: send_op(act, 16'($urandom), any_slot);
                endcase
        end
    endtask

    task automatic run_phase(input int items, input int s_idle, input int r_idle,
                             input int alloc_w, input int free_w, input int inval_w);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        repeat (items)
            random_op(alloc_w, free_w, inval_w);
    endtask

    initial
    begin : stimulus
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // full table at a tiny capacity
        set_capacity(3);
        send_op(ACT_ALLOC, 16'hFFFF, 10'd0);
        send_op(ACT_ALLOC, 16'h0000, 10'd0);
        send_op(ACT_ALLOC, 16'h1234, 10'd0);
        send_op(ACT_ALLOC, 16'h0001, 10'd0);
        wait_drained();

        // invalidate, then the old generation and wrong generations are stale
        send_op(ACT_INVALIDATE, gen_of(10'd1), 10'd1);
        send_op(ACT_INVALIDATE, 16'd1, 10'd1);
        send_op(ACT_FREE, 16'hFFFF, 10'd0);
        send_op(ACT_FREE, 16'h0000, 10'd2);
        send_op(ACT_RESERVED, 16'hFFFF, 10'd2);
        wait_drained();

        // frees with and without a moved entry, then a double free
        send_op(ACT_FREE, gen_of(10'd0), 10'd0);
        send_op(ACT_FREE, gen_of(10'd2), 10'd2);
        send_op(ACT_FREE, gen_of(10'd1), 10'd1);
        send_op(ACT_FREE, gen_of(10'd1), 10'd1);
        wait_drained();
        send_op(ACT_ALLOC, 16'h5A5A, 10'd0);
        send_op(ACT_ALLOC, 16'hA5A5, 10'd0);

        // capacity lowered under the live count: only allocation is blocked
        set_capacity(1);
        send_op(ACT_ALLOC, 16'h0000, 10'd0);
        send_op(ACT_INVALIDATE, gen_of(10'd2), 10'd2);
        send_op(ACT_FREE, gen_of(10'd1), 10'd1);
        send_op(ACT_ALLOC, 16'h0000, 10'd0);
        wait_drained();
        send_op(ACT_FREE, gen_of(10'd2), 10'd2);
        send_op(ACT_ALLOC, 16'hFFFF, 10'd0);   // reused slot lies above the limit

        set_capacity(1024);
        run_phase(380, 11, 85, 94, 2, 2);
        wait_drained();
        run_phase(320, 85, 11, 80, 8, 7);
        set_capacity(560);
        run_phase(230, 0, 0, 30, 50, 12);
        wait_drained();

        $display("%0d allocations, %0d invalidations, %0d frees accepted",
                 n_alloc, n_inval, n_free);
        $display("%0d allocations refused as full, %0d handles rejected, slots touched up to %0d",
                 n_full, n_stale, fill_mark);
        if (mismatch_count == 0 && results_pending == 0)
            $display("dense_handle_allocator: match");
        else
            $display("dense_handle_allocator: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/dha_pkg.sv
hdl/dense_handle_allocator.sv
verif/dense_handle_allocator_checker.sv
verif/dense_handle_allocator_tb.sv
